// ===== rtl/thde_pkg.sv =====
// Shared types and constants for the target heading and distance error unit.
package thde_pkg;

    // One turn is 2**TURN_BITS heading units.
    localparam int TURN_BITS  = 12;
    localparam int TURN_UNITS = 1 << TURN_BITS;
    localparam int HALF_BITS  = TURN_BITS - 1;

    // Field widths.
    localparam int POS_W  = 16;
    localparam int HEAD_W = 12;
    localparam int SQ_W   = 32;

    // Signed error, error magnitude, quotient and bearing arithmetic widths.
    localparam int ERR_W = POS_W + 1;
    localparam int MAG_W = 16;
    localparam int QUO_W = TURN_BITS + 1;
    localparam int NUM_W = MAG_W + TURN_BITS;
    localparam int BRG_W = TURN_BITS + 4;

    // Errors beyond this bound are halved so the squared distance fits in 32 bits.
    localparam logic signed [ERR_W-1:0] ERR_MAX = 17'sd46340;
    localparam logic signed [ERR_W-1:0] ERR_MIN = -17'sd46340;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 1'd1;

    // Which linear arctangent segment applies to an error pair.
    typedef enum logic [2:0] {
        BRG_X_POS,
        BRG_Y_POS,
        BRG_Y_NEG,
        BRG_XNEG_YPOS,
        BRG_XNEG_YNEG,
        BRG_ON_TARGET
    } brg_kind_t;

    typedef struct packed {
        logic [POS_W-1:0]  position_x;
        logic [POS_W-1:0]  position_y;
        logic [HEAD_W-1:0] heading;
    } sample_t;

    typedef struct packed {
        logic [HEAD_W-1:0]    heading_error;
        logic [HEAD_W-2:0]    heading_error_half;
        logic [SQ_W-1:0]      distance_squared;
        logic                 errors_halved;
    } result_t;

    // Data that rides alongside the divider without being changed by it.
    typedef struct packed {
        brg_kind_t         kind;
        logic              q_neg;
        logic [HEAD_W-1:0] head;
        logic              halved;
        logic [SQ_W-1:0]   sq_x;
        logic [SQ_W-1:0]   sq_y;
    } side_t;

    // Contents of one divider cell.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] numlo;
        side_t            side;
    } div_t;

endpackage

// ===== rtl/thde_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface thde_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/target_heading_and_distance_error_unit.sv =====
// Path of a result: 2 front stages, 13 divider cells, then 1 output register.
// One item per cycle while the skid entry is free; 13 divider cells, one quotient bit per cell.
// Results leave through an output register backed by one skid entry, so input is taken while
// a result waits. Reset (rst_n low, asynchronous) clears all valid flags and both target
// registers to zero; there is no clearing pass and the block is ready right after reset.
module target_heading_and_distance_error_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [thde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [thde_pkg::POS_W-1:0]      cfg_data,
    thde_stream_if.sink                     sample,
    thde_stream_if.source                   result
);
    import thde_pkg::*;

    logic [POS_W-1:0] target_x_reg;
    logic [POS_W-1:0] target_y_reg;
    logic             adv;
    div_t             chain_data [0:QUO_W];
    logic [QUO_W:0]   chain_valid;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= '0;
            target_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_X: target_x_reg <= cfg_data;
                CFG_TARGET_Y: target_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Error and operand preparation.
    thde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .target_x  (target_x_reg),
        .target_y  (target_y_reg),
        .sample    (sample),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // Divider chain, one quotient bit per cell.
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        thde_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Bearing, heading error and result delivery.
    thde_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[QUO_W]),
        .in_data  (chain_data[QUO_W]),
        .adv      (adv),
        .result   (result)
    );

endmodule

// ===== rtl/thde_front.sv =====
// Error forming, overflow halving, segment selection and squaring stages.
module thde_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [thde_pkg::POS_W-1:0]   target_x,
    input  logic [thde_pkg::POS_W-1:0]   target_y,
    thde_stream_if.sink                  sample,
    output logic                         out_valid,
    output thde_pkg::div_t               out_data
);
    import thde_pkg::*;

    logic signed [ERR_W-1:0] ex_raw;
    logic signed [ERR_W-1:0] ey_raw;
    logic                    over;
    logic signed [ERR_W-1:0] ex_next;
    logic signed [ERR_W-1:0] ey_next;

    logic signed [ERR_W-1:0] ex_reg;
    logic signed [ERR_W-1:0] ey_reg;
    logic                    halved_reg;
    logic [HEAD_W-1:0]       head_reg;
    logic                    s1_valid_reg;

    logic [ERR_W-1:0] ex_neg;
    logic [ERR_W-1:0] ey_neg;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             x_neg;
    logic             y_neg;
    logic             x_pos;
    logic             y_pos;
    logic             x_dom;
    logic [MAG_W-1:0] num;
    logic [NUM_W-1:0] numer;
    div_t             data_next;
    div_t             data_reg;
    logic             s2_valid_reg;

    // The front stage takes a transfer whenever the pipeline moves.
    assign sample.ready = adv;

    // Signed errors to the target, halved when either one is out of range.
    always_comb
    begin
        ex_raw  = $signed({1'b0, target_x}) - $signed({1'b0, sample.data.position_x});
        ey_raw  = $signed({1'b0, target_y}) - $signed({1'b0, sample.data.position_y});
        over    = (ex_raw > ERR_MAX) || (ex_raw < ERR_MIN)
               || (ey_raw > ERR_MAX) || (ey_raw < ERR_MIN);
        ex_next = over ? (ex_raw >>> 1) : ex_raw;
        ey_next = over ? (ey_raw >>> 1) : ey_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg     <= ex_next;
            ey_reg     <= ey_next;
            halved_reg <= over;
            head_reg   <= sample.data.heading;
        end
    end

    // Magnitudes, segment choice, divider operands and squares.
    always_comb
    begin
        ex_neg = -ex_reg;
        ey_neg = -ey_reg;
        x_neg  = ex_reg[ERR_W-1];
        y_neg  = ey_reg[ERR_W-1];
        mx     = x_neg ? ex_neg[MAG_W-1:0] : ex_reg[MAG_W-1:0];
        my     = y_neg ? ey_neg[MAG_W-1:0] : ey_reg[MAG_W-1:0];
        x_pos  = !x_neg && (mx != '0);
        y_pos  = !y_neg && (my != '0);
        x_dom  = mx > my;

        if ((mx == '0) && (my == '0))
        begin
            data_next.side.kind = BRG_ON_TARGET;
        end
        else if (x_dom)
        begin
            if (x_pos)
            begin
                data_next.side.kind = BRG_X_POS;
            end
            else if (y_pos)
            begin
                data_next.side.kind = BRG_XNEG_YPOS;
            end
            else
            begin
                data_next.side.kind = BRG_XNEG_YNEG;
            end
        end
        else if (y_pos)
        begin
            data_next.side.kind = BRG_Y_POS;
        end
        else
        begin
            data_next.side.kind = BRG_Y_NEG;
        end

        // The smaller magnitude is always the dividend, so the quotient stays within a turn.
        num   = x_dom ? my : mx;
        numer = {num, {TURN_BITS{1'b0}}};

        data_next.rem         = MAG_W'(numer[NUM_W-1:QUO_W]);
        data_next.numlo       = numer[QUO_W-1:0];
        data_next.quo         = '0;
        data_next.den         = x_dom ? mx : my;
        data_next.side.q_neg  = x_neg ^ y_neg;
        data_next.side.head   = head_reg;
        data_next.side.halved = halved_reg;
        data_next.side.sq_x   = SQ_W'(mx) * SQ_W'(mx);
        data_next.side.sq_y   = SQ_W'(my) * SQ_W'(my);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/thde_div_cell.sv =====
// One restoring division cell: settles one quotient bit and passes the item on.
module thde_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  thde_pkg::div_t in_data,
    output logic           out_valid,
    output thde_pkg::div_t out_data
);
    import thde_pkg::*;

    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic             fits;
    div_t             data_next;
    div_t             data_reg;
    logic             valid_reg;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        trial     = {in_data.rem, in_data.numlo[QUO_W-1]};
        diff      = trial - {1'b0, in_data.den};
        fits      = trial >= {1'b0, in_data.den};
        data_next = in_data;
        data_next.rem   = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        data_next.quo   = {in_data.quo[QUO_W-2:0], fits};
        data_next.numlo = {in_data.numlo[QUO_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/thde_back.sv =====
// Bearing segments, heading error, distance sum and the output skid buffer.
module thde_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  thde_pkg::div_t in_data,
    output logic           adv,
    thde_stream_if.source  result
);
    import thde_pkg::*;

    localparam logic signed [BRG_W-1:0] T1_S = BRG_W'(TURN_UNITS);
    localparam logic signed [BRG_W-1:0] T3_S = BRG_W'(3 * TURN_UNITS);

    logic [BRG_W-1:0]        quo_ext;
    logic signed [BRG_W-1:0] q_s;
    logic signed [BRG_W-1:0] head_s;
    logic signed [BRG_W-1:0] brg;
    logic [BRG_W-1:0]        diff;
    result_t                 res_next;

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;
    logic    push;
    logic    pop;

    // Signed quotient, the segment's linear bearing and the wrapped heading error.
    always_comb
    begin
        quo_ext = BRG_W'(in_data.quo);
        q_s     = $signed(in_data.side.q_neg ? (~quo_ext + 1'b1) : quo_ext);
        head_s  = $signed(BRG_W'(in_data.side.head));

        case (in_data.side.kind)
            BRG_X_POS:     brg = (T1_S + (q_s >>> 2)) >>> 1;
            BRG_Y_POS:     brg = (T3_S - (q_s >>> 1)) >>> 2;
            BRG_Y_NEG:     brg = (T1_S - (q_s >>> 1)) >>> 2;
            BRG_XNEG_YPOS: brg = T1_S + (q_s >>> 3);
            BRG_XNEG_YNEG: brg = q_s >>> 3;
            default:       brg = head_s;
        endcase

        // The low bits of the two's complement difference are the error modulo a turn.
        diff = brg - head_s;

        res_next.heading_error      = diff[HEAD_W-1:0];
        res_next.heading_error_half = diff[HALF_BITS-1:0];
        res_next.distance_squared   = in_data.side.sq_x + in_data.side.sq_y;
        res_next.errors_halved      = in_data.side.halved;
    end

    // The pipeline moves while the skid entry is free.
    assign adv  = !skid_valid_reg;
    assign push = adv && in_valid;
    assign pop  = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload moves into the output register or parks in the skid entry.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the target heading and distance error unit.
module testbench;
    import thde_pkg::*;

    localparam int     PHASE_ITEMS = 255;
    localparam int     HOLD_OFF    = 150;
    localparam int     STALL_LIMIT = 2000;
    localparam int     TAIL_CYCLES = 24;
    localparam longint GUARD_BOUND = 46340;

    // Predicts one steering result per position sample and checks results in order.
    class steer_scoreboard;
        logic [POS_W-1:0] aim_x = '0;
        logic [POS_W-1:0] aim_y = '0;
        result_t steer_due[$];
        int failures = 0;
        int samples_seen = 0;
        int results_seen = 0;
        int halved_seen = 0;
        int arrivals_seen = 0;

        function void set_target(logic [CFG_IDX_W-1:0] index, logic [POS_W-1:0] value);
            if (index == CFG_TARGET_X)
                aim_x = value;
            else if (index == CFG_TARGET_Y)
                aim_y = value;
        endfunction

        // Scaled ratio, truncated toward zero.
        function longint quot(longint a, longint b);
            if (b == 0)
                return 0;
            return (a * TURN_UNITS) / b;
        endfunction

        // Octant-wise linear arctangent of the error pair.
        function longint bearing_of(longint ex, longint ey, longint head);
            longint t;
            t = TURN_UNITS;
            if (ex > 0)
            begin
                if (ey > 0)
                begin
                    if (ex > ey)
                        return (t + (quot(ey, ex) >>> 2)) >>> 1;
                    return (3 * t - (quot(ex, ey) >>> 1)) >>> 2;
                end
                if (ex > -ey)
                    return (t + (quot(ey, ex) >>> 2)) >>> 1;
                return (t - (quot(ex, ey) >>> 1)) >>> 2;
            end
            if (ey > 0)
            begin
                if (-ex > ey)
                    return t + (quot(ey, ex) >>> 3);
                return (3 * t - (quot(ex, ey) >>> 1)) >>> 2;
            end
            if (-ex > -ey)
                return quot(ey, ex) >>> 3;
            // On target the bearing is the current heading.
            if (ey == 0)
                return head;
            return (t - (quot(ex, ey) >>> 1)) >>> 2;
        endfunction

        function result_t steer_for(sample_t s);
            longint t;
            longint ex;
            longint ey;
            longint head;
            longint brg;
            longint err;
            longint half;
            longint span_sq;
            result_t r;
            t = TURN_UNITS;
            ex = longint'(aim_x) - longint'(s.position_x);
            ey = longint'(aim_y) - longint'(s.position_y);
            head = longint'(s.heading);
            r.errors_halved = 1'b0;
            // Either error out of range halves both, so the square sum fits in 32 bits.
            if (ex > GUARD_BOUND || ex < -GUARD_BOUND || ey > GUARD_BOUND || ey < -GUARD_BOUND)
            begin
                ex = ex >>> 1;
                ey = ey >>> 1;
                r.errors_halved = 1'b1;
            end
            brg = bearing_of(ex, ey, head);
            err = (brg - head) % t;
            if (err < 0)
                err += t;
            half = err % (t / 2);
            span_sq = ex * ex + ey * ey;
            r.heading_error = err[HEAD_W-1:0];
            r.heading_error_half = half[HEAD_W-2:0];
            r.distance_squared = span_sq[SQ_W-1:0];
            return r;
        endfunction

        function void note_sample(sample_t s);
            result_t r;
            r = steer_for(s);
            samples_seen++;
            if (r.errors_halved)
                halved_seen++;
            if (s.position_x == aim_x && s.position_y == aim_y)
                arrivals_seen++;
            steer_due.push_back(r);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                failures++;
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (steer_due.size() == 0)
            begin
                failures++;
                $error("result transfer with no expectation waiting");
                return;
            end
            want = steer_due.pop_front();
            compare_field("heading_error", want.heading_error, got.heading_error);
            compare_field("heading_error_half", want.heading_error_half,
                          got.heading_error_half);
            compare_field("distance_squared", want.distance_squared, got.distance_squared);
            compare_field("errors_halved", want.errors_halved, got.errors_halved);
        endfunction

        function int pending();
            return steer_due.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TARGET_X;
    logic [POS_W-1:0]     cfg_data = '0;
    logic                 sample_offer = 1'b0;
    sample_t              sample_word = '0;
    logic                 result_take = 1'b0;

    int send_idle_pct = 10;
    int recv_idle_pct = 46;
    int stall_requests = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int stalled_cycles = 0;
    int settings_done = 0;

    steer_scoreboard steer_check = new();

    thde_stream_if #(.payload_t(sample_t)) sample_ch ();
    thde_stream_if #(.payload_t(result_t)) result_ch ();

    assign sample_ch.valid = sample_offer;
    assign sample_ch.data  = sample_word;
    assign result_ch.ready = result_take;

    target_heading_and_distance_error_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (stall_requests != stall_seen)
        begin
            stall_seen = stall_requests;
            stall_left = HOLD_OFF;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_take <= 1'b0;
        end
        else
            result_take <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            steer_check.check_result(result_ch.data);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic logic [POS_W-1:0] place(longint aim, longint e);
        longint p;
        p = aim - e;
        return p[POS_W-1:0];
    endfunction

    function automatic longint spread(longint span);
        return longint'($urandom_range(32'(2 * span))) - span;
    endfunction

    // Mix of uniform positions and positions placed at chosen errors from the target.
    function automatic sample_t random_sample(logic [POS_W-1:0] ax, logic [POS_W-1:0] ay);
        sample_t s;
        longint ex;
        longint ey;
        longint d;
        int kind;
        kind = $urandom_range(9);
        ex = 0;
        ey = 0;
        s.position_x = POS_W'($urandom_range(65535));
        s.position_y = POS_W'($urandom_range(65535));
        case (kind)
            3, 4:
            begin
                ex = spread(200);
                ey = spread(200);
            end
            5:
            begin
                ex = spread(6000);
                ey = spread(6000);
            end
            6:
            begin
                // One error is zero.
                if ($urandom_range(1))
                    ey = spread(3000);
                else
                    ex = spread(3000);
            end
            7:
            begin
                // Errors of equal size sit on an octant border.
                d = longint'($urandom_range(20000, 1));
                ex = $urandom_range(1) ? d : -d;
                ey = $urandom_range(1) ? d : -d;
            end
            8:
            begin
                // One error right at or just past the halving bound.
                d = GUARD_BOUND + longint'($urandom_range(1));
                ex = $urandom_range(1) ? d : -d;
                ey = spread(100);
                if ($urandom_range(1))
                begin
                    ey = ex;
                    ex = spread(100);
                end
            end
            default:
            begin
            end
        endcase
        if (kind >= 3)
        begin
            s.position_x = place(ax, ex);
            s.position_y = place(ay, ey);
        end
        if ($urandom_range(15) == 0)
            s.heading = $urandom_range(1) ? '1 : '0;
        else
            s.heading = HEAD_W'($urandom_range(4095));
        return s;
    endfunction

    function automatic sample_t make_sample(longint px, longint py, longint head);
        sample_t s;
        s.position_x = px[POS_W-1:0];
        s.position_y = py[POS_W-1:0];
        s.heading = head[HEAD_W-1:0];
        return s;
    endfunction

    // Offer one sample, with random idle cycles first, and return on its transfer.
    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_offer <= 1'b0;
            @(posedge clk);
        end
        sample_offer <= 1'b1;
        sample_word <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        steer_check.note_sample(s);
    endtask

    // Stop offering and wait until every predicted result has been checked.
    task automatic drain();
        sample_offer <= 1'b0;
        do
            @(posedge clk);
        while (steer_check.pending() != 0);
    endtask

    task automatic set_targets(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TARGET_X;
        cfg_data <= x;
        @(posedge clk);
        cfg_index <= CFG_TARGET_Y;
        cfg_data <= y;
        @(posedge clk);
        cfg_we <= 1'b0;
        steer_check.set_target(CFG_TARGET_X, x);
        steer_check.set_target(CFG_TARGET_Y, y);
        settings_done++;
    endtask

    initial
    begin
        int octant_ofs [16][2];
        logic [POS_W-1:0] tx;
        logic [POS_W-1:0] ty;
        int phase;
        int n;

        octant_ofs = '{
            '{1000, 300}, '{300, 1000}, '{1000, 1000}, '{1000, -300},
            '{300, -1000}, '{1000, -1000}, '{-1000, 300}, '{-300, 1000},
            '{-1000, 1000}, '{-1000, -300}, '{-300, -1000}, '{-1000, -1000},
            '{1000, 0}, '{-1000, 0}, '{0, 1000}, '{0, -1000}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Targets at reset are zero: on target, the halving bound on each axis, far corner.
        send_sample(make_sample(0, 0, 0));
        send_sample(make_sample(0, 0, 4095));
        send_sample(make_sample(46340, 0, 100));
        send_sample(make_sample(46341, 0, 2000));
        send_sample(make_sample(0, 46341, 3000));
        send_sample(make_sample(65535, 65535, 4095));
        send_sample(make_sample(0, 1, 1));
        drain();

        // Largest positive errors.
        set_targets(16'hFFFF, 16'hFFFF);
        send_sample(make_sample(0, 0, 0));
        send_sample(make_sample(19194, 65535, 2048));
        drain();

        // Every octant, every octant border and every axis around a central target.
        set_targets(16'h8000, 16'h8000);
        for (n = 0; n < 16; n++)
            send_sample(make_sample(32768 - octant_ofs[n][0], 32768 - octant_ofs[n][1],
                                    longint'($urandom_range(4095))));

        for (phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    tx = '0;
                    ty = '0;
                end
                1:
                begin
                    tx = '1;
                    ty = '1;
                end
                2:
                begin
                    tx = '0;
                    ty = '1;
                end
                3:
                begin
                    tx = '1;
                    ty = '0;
                end
                default:
                begin
                    tx = POS_W'($urandom_range(65535));
                    ty = POS_W'($urandom_range(65535));
                end
            endcase
            set_targets(tx, ty);
            if (phase < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 46;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Long receiver hold-off while samples keep coming, so the unit backs up.
                if (phase == 4 && n == 100)
                    stall_requests++;
                // Sender pause until the unit has emptied.
                if (phase == 4 && n == 200)
                    drain();
                send_sample(random_sample(tx, ty));
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d position samples over %0d target settings and three idle patterns.",
                 steer_check.samples_seen, settings_done);
        $display("Checked %0d results: %0d with halved errors, %0d on target.",
                 steer_check.results_seen, steer_check.halved_seen, steer_check.arrivals_seen);
        if (steer_check.failures == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
